>>> rtl/core/glzw_pkg.sv
// Package for the LZW compressor: types, constants and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package glzw_pkg;
  localparam int MaxCodeBits = 12;
  localparam int HashBits = 13;
  localparam int HashSlots = 1 << HashBits;
  localparam logic [11:0] FullCode = 12'd4095;

  localparam logic [1:0] RegBitsPerPixel = 2'd0;
  localparam logic [1:0] RegOffset = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_READ, ST_CHECK, ST_EMIT_PREFIX,
    ST_EMIT_CLEAR, ST_EMIT_FINAL, ST_EMIT_END
  } glzw_state_t;

  typedef enum logic [1:0] {
    EM_CLEAR, EM_PREFIX, EM_FINAL, EM_END
  } glzw_emit_t;

  typedef struct packed {
    logic       clr_step;
    logic       take;
    logic       start;
    logic       rd;
    logic       probe_next;
    logic       hit;
    logic       insert;
    logic       restart;
    logic       load_prefix;
    logic       emit;
    glzw_emit_t emit_kind;
    logic       emit_last;
    logic       end_stream;
  } glzw_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic slot_hit;
    logic slot_empty;
    logic dict_full;
    logic out_free;
    logic last;
  } glzw_sts_t;

  function automatic logic [3:0] root_of(input logic [3:0] bpp);
    if (bpp < 4'd2) return 4'd2;
    if (bpp > 4'd8) return 4'd8;
    return bpp;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/glzw_stream_if.sv
// Valid/ready stream interfaces for pixel beats and code beats.
`timescale 1ns / 1ps
`default_nettype none
interface glzw_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       stream_last;
  modport source (output valid, pixel, stream_last, input ready);
  modport sink (input valid, pixel, stream_last, output ready);
endinterface

interface glzw_code_if;
  logic        valid;
  logic        ready;
  logic [11:0] code;
  logic [3:0]  code_width;
  logic        end_of_stream;
  logic        run_last;
  modport source (output valid, code, code_width, end_of_stream, run_last, input ready);
  modport sink (input valid, code, code_width, end_of_stream, run_last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/gif_lzw_compressor_core.sv
// Top level of the GIF LZW compressor: controller plus datapath.
// Usage:
// Pixel beats enter on pix (valid/ready), one byte each with stream_last
// on the final byte of a stream. Code beats leave on cod, each carrying
// the code, its width, an end-of-stream flag and run_last on the last code
// caused by a pixel. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data), written by the user only while the block is idle;
// the block itself does not enforce this. One pixel is taken at a time.
// The first pixel of a stream is taken, then the clear code is emitted.
// Later pixels pass take, read and check on a hit, and take, read, check,
// emit and insert on a miss, plus a linear probe step per collision. The
// last pixel adds the final and end codes; a full dictionary adds the
// clear code. After reset, after every dictionary restart and after every
// stream end, a clearing pass sweeps the 8192-entry dictionary while no
// pixel is taken. A stalled receiver holds the output register; the block
// waits for it before writing the next code and takes no pixel meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_compressor_core
  import glzw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  glzw_pixel_if.sink      pix,
  glzw_code_if.source     cod
);
  glzw_cmd_t cmd;
  glzw_sts_t sts;

  glzw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(pix.valid), .sts(sts), .cmd(cmd)
  );

  glzw_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .pix(pix), .cod(cod)
  );
endmodule
`default_nettype wire

>>> rtl/core/glzw_datapath.sv
// Datapath: dictionary memory, prefix and width registers, output register.
`timescale 1ns / 1ps
`default_nettype none
module glzw_datapath
  import glzw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire glzw_cmd_t  cmd,
  output glzw_sts_t       sts,
  glzw_pixel_if.sink      pix,
  glzw_code_if.source     cod
);
  logic [32:0] mem [HashSlots];
  logic [32:0] rd_data;
  logic [HashBits-1:0] addr;
  logic [HashBits-1:0] rd_addr;
  logic [HashBits:0] clr_addr;
  logic [3:0] bpp;
  logic [1:0] offset;
  logic [3:0] root;
  logic [1:0] off_l;
  logic [11:0] prefix;
  logic [11:0] nfc;
  logic [3:0] width;
  logic [12:0] limit;
  logic [7:0] px;
  logic last;
  logic [19:0] key;
  logic [3:0] root_new;
  logic [3:0] mask_root;
  logic [11:0] nfc_inc;
  logic grow;
  logic [3:0] width_g;
  logic [12:0] limit_g;
  logic [11:0] emit_code;

  assign root_new = root_of(bpp);
  assign mask_root = cmd.start ? root_new : root;
  assign key = {px, prefix};
  assign nfc_inc = nfc + 12'd1;
  assign grow = (width < 4'(MaxCodeBits)) &&
                (({1'b0, nfc} + 13'(off_l)) > limit);
  assign width_g = grow ? width + 4'd1 : width;
  assign limit_g = grow ? {limit[11:0], 1'b0} : limit;
  assign rd_addr = cmd.rd ? key[HashBits-1:0] :
                   cmd.probe_next ? addr + HashBits'(1) : addr;

  always_comb begin
    case (cmd.emit_kind)
      EM_CLEAR:  emit_code = 12'd1 << root;
      EM_PREFIX: emit_code = prefix;
      EM_FINAL:  emit_code = prefix;
      EM_END:    emit_code = (12'd1 << root) + 12'd1;
      default:   emit_code = prefix;
    endcase
  end

  assign sts.clr_done = clr_addr[HashBits];
  assign sts.slot_empty = !rd_data[32];
  assign sts.slot_hit = rd_data[32] && (rd_data[31:12] == key);
  assign sts.dict_full = nfc_inc >= FullCode;
  assign sts.out_free = !cod.valid || cod.ready;
  assign sts.last = last;
  assign pix.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr[HashBits-1:0]] <= '0;
    end else if (cmd.insert) begin
      mem[addr] <= {1'b1, key, nfc};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      addr <= '0;
      bpp <= 4'd8;
      offset <= 2'd0;
      prefix <= '0;
      root <= 4'd8;
      off_l <= 2'd0;
      nfc <= 12'd258;
      width <= 4'd9;
      limit <= 13'd512;
      px <= '0;
      last <= 1'b0;
      cod.valid <= 1'b0;
      cod.code <= '0;
      cod.code_width <= '0;
      cod.end_of_stream <= 1'b0;
      cod.run_last <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + (HashBits + 1)'(1);
      else clr_addr <= '0;
      if (cfg_we && cfg_index == 4'(RegBitsPerPixel)) bpp <= cfg_data;
      if (cfg_we && cfg_index == 4'(RegOffset)) offset <= cfg_data[1:0];
      if (cmd.emit) begin
        cod.valid <= 1'b1;
        cod.code <= emit_code;
        cod.code_width <= width_g;
        cod.end_of_stream <= cmd.emit_kind == EM_END;
        cod.run_last <= cmd.emit_last;
      end else if (cod.ready) begin
        cod.valid <= 1'b0;
      end
      if (cmd.start) begin
        root <= root_new;
        off_l <= offset;
      end
      if (cmd.start) begin
        nfc <= (12'd1 << root_new) + 12'd2;
        width <= root_new + 4'd1;
        limit <= 13'd1 << (root_new + 4'd1);
      end else if (cmd.restart) begin
        nfc <= (12'd1 << root) + 12'd2;
        width <= root + 4'd1;
        limit <= 13'd1 << (root + 4'd1);
      end else begin
        if (cmd.insert) nfc <= nfc_inc;
        if (cmd.emit) begin
          width <= width_g;
          limit <= limit_g;
        end
      end
      if (cmd.rd) addr <= key[HashBits-1:0];
      else if (cmd.probe_next) addr <= addr + HashBits'(1);
      if (cmd.end_stream) prefix <= '0;
      else if (cmd.hit) prefix <= rd_data[11:0];
      else if (cmd.insert || cmd.load_prefix) prefix <= {4'd0, px};
      if (cmd.take) begin
        px <= pix.pixel & ((8'd1 << mask_root) - 8'd1);
        last <= pix.stream_last;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/glzw_ctrl.sv
// Controller: sequences clearing, lookup, insertion and code emission.
`timescale 1ns / 1ps
`default_nettype none
module glzw_ctrl
  import glzw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire glzw_sts_t sts,
  output glzw_cmd_t      cmd
);
  glzw_state_t state, state_next;
  logic have, have_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      have <= 1'b0;
    end else begin
      state <= state_next;
      have <= have_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.emit_kind = EM_PREFIX;
    state_next = state;
    have_next = have;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = !sts.clr_done;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (!have) begin
            cmd.start = 1'b1;
            state_next = ST_START;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_START: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_CLEAR;
          cmd.emit_last = !sts.last;
          cmd.load_prefix = 1'b1;
          have_next = 1'b1;
          state_next = sts.last ? ST_EMIT_FINAL : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.slot_hit) begin
          cmd.hit = 1'b1;
          state_next = sts.last ? ST_EMIT_FINAL : ST_IDLE;
        end else if (sts.slot_empty) begin
          state_next = ST_EMIT_PREFIX;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      ST_EMIT_PREFIX: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_last = !sts.last && !sts.dict_full;
          cmd.insert = 1'b1;
          if (sts.dict_full) state_next = ST_EMIT_CLEAR;
          else state_next = sts.last ? ST_EMIT_FINAL : ST_IDLE;
        end
      end
      ST_EMIT_CLEAR: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_CLEAR;
          cmd.emit_last = !sts.last;
          cmd.restart = 1'b1;
          state_next = sts.last ? ST_EMIT_FINAL : ST_CLEAR;
        end
      end
      ST_EMIT_FINAL: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_FINAL;
          state_next = ST_EMIT_END;
        end
      end
      ST_EMIT_END: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EM_END;
          cmd.emit_last = 1'b1;
          cmd.end_stream = 1'b1;
          have_next = 1'b0;
          state_next = ST_CLEAR;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> tb/sv/lzw_code_checker.sv
// Checker for the LZW compressor: follows the register port and both channels and checks codes.
`timescale 1ns / 1ps
module lzw_code_checker
  import glzw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_index,
  input  logic [3:0] cfg_data,
  glzw_pixel_if      pix,
  glzw_code_if       cod,
  output int         errors,
  output int         pending
);
  typedef struct {
    logic [11:0] code;
    logic [3:0]  code_width;
    logic        end_of_stream;
    logic        run_last;
  } lzw_code_t;

  lzw_code_t   codes_due[$];
  logic [11:0] phrase_table[int];
  logic [3:0]  depth_reg;
  logic [1:0]  offset_reg;
  int          root_bits;
  int          offset_held;
  logic [11:0] prefix;
  logic        in_stream;
  int          next_code;
  int          width_now;
  int          width_top;

  function automatic int pixel_root(input logic [3:0] bpp);
    if (bpp < 4'd2) return 2;
    if (bpp > 4'd8) return 8;
    return int'(bpp);
  endfunction

  function automatic void restart_table();
    phrase_table.delete();
    width_now = root_bits + 1;
    next_code = (1 << root_bits) + 2;
    width_top = 1 << width_now;
  endfunction

  function automatic void push_code(input int value, input logic eos);
    lzw_code_t c;
    if (width_now < MaxCodeBits && next_code + offset_held > width_top) begin
      width_now++;
      width_top = width_top << 1;
    end
    c.code = value[11:0];
    c.code_width = width_now[3:0];
    c.end_of_stream = eos;
    c.run_last = 1'b0;
    codes_due.insert(codes_due.size(), c);
  endfunction

  function automatic void encode_pixel(input logic [7:0] px_in, input logic last);
    int          count_at_entry;
    int          px;
    int          key;
    count_at_entry = codes_due.size();
    px = int'(px_in) & ((1 << root_bits) - 1);
    if (!in_stream) begin
      root_bits = pixel_root(depth_reg);
      offset_held = int'(offset_reg);
      restart_table();
      push_code(1 << root_bits, 1'b0);
      px = int'(px_in) & ((1 << root_bits) - 1);
      prefix = px[11:0];
      in_stream = 1'b1;
    end else begin
      key = (px << 12) | int'(prefix);
      if (phrase_table.exists(key)) begin
        prefix = phrase_table[key];
      end else begin
        push_code(int'(prefix), 1'b0);
        phrase_table[key] = next_code[11:0];
        next_code++;
        if (next_code >= int'(FullCode)) begin
          push_code(1 << root_bits, 1'b0);
          restart_table();
        end
        prefix = px[11:0];
      end
    end
    if (last) begin
      push_code(int'(prefix), 1'b0);
      push_code((1 << root_bits) + 1, 1'b1);
      in_stream = 1'b0;
      prefix = '0;
    end
    if (codes_due.size() > count_at_entry) begin
      codes_due[codes_due.size() - 1].run_last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    lzw_code_t want;
    if (rst) begin
      errors = 0;
      codes_due.delete();
      depth_reg = 4'd8;
      offset_reg = 2'd0;
      root_bits = 8;
      offset_held = 0;
      prefix = '0;
      in_stream = 1'b0;
      restart_table();
    end else begin
      if (cfg_we) begin
        if (cfg_index == 4'(RegBitsPerPixel)) depth_reg = cfg_data;
        else if (cfg_index == 4'(RegOffset)) offset_reg = cfg_data[1:0];
      end
      if (pix.valid && pix.ready) encode_pixel(pix.pixel, pix.stream_last);
      if (cod.valid && cod.ready) begin
        if (codes_due.size() == 0) begin
          $display("%0t: unexpected code beat: expected none, actual code %0d width %0d",
                   $time, cod.code, cod.code_width);
          errors++;
        end else begin
          want = codes_due.pop_front();
          if (cod.code !== want.code || cod.code_width !== want.code_width ||
              cod.end_of_stream !== want.end_of_stream || cod.run_last !== want.run_last) begin
            $display("%0t: code beat differs: expected %0d/%0d/%0b/%0b, actual %0d/%0d/%0b/%0b",
                     $time, want.code, want.code_width, want.end_of_stream, want.run_last,
                     cod.code, cod.code_width, cod.end_of_stream, cod.run_last);
            errors++;
          end
        end
      end
    end
    pending = codes_due.size();
  end
endmodule

>>> tb/sv/tb.sv
// Testbench top for the LZW compressor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb
  import glzw_pkg::*;
();

  localparam int CycleLimit = 3000000;
  localparam int ClearWait = 8400;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_index;
  logic [3:0] cfg_data;
  int         errors;
  int         pending;
  int         cycles;
  int         burst_left;
  int         hold_cycles;
  int         rx_mode;
  int         rx_age;
  logic       hold_req;
  logic       hold_taken;

  glzw_pixel_if pix_if ();
  glzw_code_if  cod_if ();

  gif_lzw_compressor_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix_if), .cod(cod_if)
  );

  lzw_code_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix_if), .cod(cod_if),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("gif_lzw_compressor_core: mismatch");
      $finish;
    end
  end

  // The receiver switches at random among stall patterns and holds one long stall on request.
  always @(negedge clk) begin
    if (rst) begin
      cod_if.ready <= 1'b0;
      hold_taken <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      cod_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_cycles <= 400;
      hold_taken <= 1'b1;
      cod_if.ready <= 1'b0;
    end else begin
      if (rx_age == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_age <= $urandom_range(50, 300);
      end else begin
        rx_age <= rx_age - 1;
      end
      case (rx_mode)
        0: cod_if.ready <= 1'b1;
        1: cod_if.ready <= 1'($urandom_range(0, 1));
        default: cod_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_pixel(input logic [7:0] px, input logic last);
    int gap;
    if (burst_left == 0) begin
      pix_if.valid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    pix_if.valid = 1'b1;
    pix_if.pixel = px;
    pix_if.stream_last = last;
    do @(posedge clk); while (!pix_if.ready);
    @(negedge clk);
    pix_if.valid = 1'b0;
  endtask

  task automatic drain_and_rest();
    pix_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (ClearWait) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [3:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_mode(input logic [3:0] depth, input logic [1:0] offset);
    drain_and_rest();
    write_reg(4'(RegBitsPerPixel), depth);
    write_reg(4'(RegOffset), {2'b00, offset});
  endtask

  task automatic send_run(input int len, input logic narrow);
    logic [7:0] px;
    for (int i = 0; i < len; i++) begin
      px = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
      send_pixel(px, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    logic held;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.stream_last = 1'b0;
    burst_left = 0;
    hold_req = 1'b0;
    held = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    set_mode(4'd8, 2'd0);
    send_pixel(8'h00, 1'b1);
    set_mode(4'd0, 2'd3);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h03, 1'b1);
    set_mode(4'd1, 2'd1);
    for (int i = 0; i < 6; i++) send_pixel(8'(i % 2 + 1), i == 5);
    set_mode(4'd15, 2'd2);
    write_reg(4'd7, 4'd5);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7F, 1'b1);
    set_mode(4'd8, 2'd0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b0);
    // Depth written in the middle of a stream only takes effect on the next one.
    drain_and_rest();
    write_reg(4'(RegBitsPerPixel), 4'd3);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b1);

    sent = 0;
    while (sent < 88) begin
      if ($urandom_range(0, 1) == 0) begin
        set_mode(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0) write_reg(4'($urandom_range(2, 15)), 4'($urandom));
      end
      len = $urandom_range(1, 16);
      if (!held && sent >= 40) begin
        drain_and_rest();
        hold_req = 1'b1;
        held = 1'b1;
        len = 12;
      end
      send_run(len, 1'($urandom_range(0, 1)));
      hold_req = 1'b0;
      sent += len;
    end

    drain_and_rest();
    if (errors == 0) begin
      $display("gif_lzw_compressor_core: match");
    end else begin
      $display("gif_lzw_compressor_core: mismatch");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/glzw_pkg.sv
rtl/core/glzw_stream_if.sv
rtl/core/glzw_datapath.sv
rtl/core/glzw_ctrl.sv
rtl/core/gif_lzw_compressor_core.sv
tb/sv/lzw_code_checker.sv
tb/sv/tb.sv
